// ===== hw/rtl/trs_affine_matrix_builder_defines.svh =====
// Assertion macros shared by the affine matrix builder RTL.
`ifndef TRS_AFFINE_MATRIX_BUILDER_DEFINES_SVH
`define TRS_AFFINE_MATRIX_BUILDER_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define AMB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define AMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/trs_amb_pkg.sv =====
// Shared types and constants of the affine matrix builder.
package trs_amb_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam longint GAIN_Q30 = 64'd652032874;

  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic [2:0][31:0] trans;
    logic [2:0][23:0] scale;
  } pose_t;

  typedef logic [2:0][2:0][31:0] mat_t;

endpackage

// ===== hw/rtl/trs_amb_cordic.sv =====
// Pipelined rotation-mode CORDIC giving sine and cosine of a binary angle.
module trs_amb_cordic #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       vld,
  input  logic signed [15:0]         angle,
  output logic                       res_vld,
  output logic signed [FRAC_BITS+2:0] cos_val,
  output logic signed [FRAC_BITS+2:0] sin_val
);
  import trs_amb_pkg::*;

  localparam int W = FRAC_BITS + 3;
  localparam int ZW = 34;
  localparam int N = CORDIC_STAGES;
  localparam longint GAIN_R =
    (GAIN_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  logic signed [W-1:0]  x [0:N];
  logic signed [W-1:0]  y [0:N];
  logic signed [ZW-1:0] z [0:N];
  logic                 flip [0:N];
  logic                 v [0:N];

  logic signed [16:0] a_ext;
  logic signed [16:0] a_fold;
  logic               a_flip;

  always_comb begin
    a_ext = {angle[15], angle};
    a_fold = a_ext;
    a_flip = 1'b0;
    if (a_ext > 17'sd16384) begin
      a_fold = a_ext - 17'sd32768;
      a_flip = 1'b1;
    end else if (a_ext < -17'sd16384) begin
      a_fold = a_ext + 17'sd32768;
      a_flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    x[0] <= W'(GAIN_R);
    y[0] <= '0;
    z[0] <= {a_fold[16], a_fold, 16'b0};
    flip[0] <= a_flip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= vld;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!z[i][ZW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - $signed({2'b00, ATAN_TURN32[i]});
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + $signed({2'b00, ATAN_TURN32[i]});
      end
      flip[i+1] <= flip[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    cos_val <= flip[N] ? -x[N] : x[N];
    sin_val <= flip[N] ? -y[N] : y[N];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else begin
      res_vld <= v[N];
    end
  end

endmodule

// ===== hw/rtl/trs_amb_rot.sv =====
// Four-stage pipeline forming the scaled rotation matrix from sines and cosines.
module trs_amb_rot #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vld,
  input  logic signed [FRAC_BITS+2:0] cx,
  input  logic signed [FRAC_BITS+2:0] sx,
  input  logic signed [FRAC_BITS+2:0] cy,
  input  logic signed [FRAC_BITS+2:0] sy,
  input  logic signed [FRAC_BITS+2:0] cz,
  input  logic signed [FRAC_BITS+2:0] sz,
  input  trs_amb_pkg::pose_t          pose,
  output logic                        res_vld,
  output trs_amb_pkg::mat_t           mat,
  output trs_amb_pkg::pose_t          res_pose
);
  import trs_amb_pkg::*;

  localparam int W = FRAC_BITS + 3;
  localparam int RW = W + 1;
  localparam int PRW = RW + 24;
  localparam logic signed [2*W-1:0] HALF_T = (2*W)'(1) << (FRAC_BITS - 1);
  localparam logic signed [PRW-1:0] HALF_P = PRW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PRW-1:0] MAXV = PRW'(32'h7fffffff);
  localparam logic signed [PRW-1:0] MINV = -MAXV - PRW'(1);

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    p = p + HALF_T;
    return W'(p >>> FRAC_BITS);
  endfunction

  logic                v1, v2, v3;
  pose_t               pose1, pose2, pose3;
  logic signed [W-1:0] sxsy, cxsy, cycz, cysz, cxsz, cxcz, sxcy, sxsz, sxcz, cxcy;
  logic signed [W-1:0] sy1, cz1, sz1;
  logic signed [RW-1:0] r [3][3];
  logic signed [PRW-1:0] prod [3][3];
  logic signed [PRW-1:0] shifted [3][3];

  always_ff @(posedge clk) begin
    sxsy <= fmul(sx, sy);
    cxsy <= fmul(cx, sy);
    cycz <= fmul(cy, cz);
    cysz <= fmul(cy, sz);
    cxsz <= fmul(cx, sz);
    cxcz <= fmul(cx, cz);
    sxcy <= fmul(sx, cy);
    sxsz <= fmul(sx, sz);
    sxcz <= fmul(sx, cz);
    cxcy <= fmul(cx, cy);
    sy1 <= sy;
    cz1 <= cz;
    sz1 <= sz;
    pose1 <= pose;
  end

  always_ff @(posedge clk) begin
    r[0][0] <= RW'(cycz);
    r[0][1] <= -RW'(cysz);
    r[0][2] <= RW'(sy1);
    r[1][0] <= RW'(fmul(sxsy, cz1)) + RW'(cxsz);
    r[1][1] <= RW'(cxcz) - RW'(fmul(sxsy, sz1));
    r[1][2] <= -RW'(sxcy);
    r[2][0] <= RW'(sxsz) - RW'(fmul(cxsy, cz1));
    r[2][1] <= RW'(fmul(cxsy, sz1)) + RW'(sxcz);
    r[2][2] <= RW'(cxcy);
    pose2 <= pose1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= r[i][j] * $signed(pose2.scale[j]);
      end
    end
    pose3 <= pose2;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        shifted[i][j] = (prod[i][j] + HALF_P) >>> FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (shifted[i][j] > MAXV) begin
          mat[i][j] <= 32'h7fffffff;
        end else if (shifted[i][j] < MINV) begin
          mat[i][j] <= 32'h80000000;
        end else begin
          mat[i][j] <= shifted[i][j][31:0];
        end
      end
    end
    res_pose <= pose3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      v1 <= vld;
      v2 <= v1;
      v3 <= v2;
      res_vld <= v3;
    end
  end

endmodule

// ===== hw/rtl/trs_affine_matrix_builder.sv =====
// Top level of the affine matrix builder: CORDIC units, matrix pipeline, row output.
// Row 0 is strobed from the output register after the CORDIC units and the matrix pipeline,
// then rows 1 and 2 follow in order, straight after it.
// A new pose is accepted only while busy is low, since the single result port carries three rows.
// busy is high after each accepted transaction while the gap counter runs down.
// Synchronous reset clears all valid bits and the output strobe; no clearing pass.
module trs_affine_matrix_builder #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  input  logic signed [23:0] scale_x,
  input  logic signed [23:0] scale_y,
  input  logic signed [23:0] scale_z,
  output logic               strobe,
  output logic [1:0]         row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);
  import trs_amb_pkg::*;
  `include "trs_affine_matrix_builder_defines.svh"

  localparam int W = FRAC_BITS + 3;
  localparam int LAT_C = CORDIC_STAGES + 2;

  logic [1:0] gap;
  logic       accept;
  pose_t      pose_in;
  pose_t      pd [0:LAT_C];
  logic       cvx, cvy, cvz;
  logic signed [W-1:0] cx, sx, cy, sy, cz, sz;
  logic       rot_vld;
  mat_t       mat;
  pose_t      rot_pose;
  mat_t       hold;
  logic [2:0][31:0] hold_t;
  logic [1:0] rows_left;
  logic [1:0] row_sel;

  assign accept = start && !busy;
  assign busy = (gap != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 2'd0;
    end else if (accept) begin
      gap <= 2'd2;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  always_comb begin
    pose_in.trans = {trans_z, trans_y, trans_x};
    pose_in.scale = {scale_z, scale_y, scale_x};
  end

  assign pd[0] = pose_in;
  for (genvar i = 0; i < LAT_C; i++) begin : g_delay
    always_ff @(posedge clk) begin
      pd[i+1] <= pd[i];
    end
  end

  trs_amb_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_x (
    .clk(clk), .rst(rst), .vld(accept), .angle(angle_x),
    .res_vld(cvx), .cos_val(cx), .sin_val(sx)
  );
  trs_amb_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_y (
    .clk(clk), .rst(rst), .vld(accept), .angle(angle_y),
    .res_vld(cvy), .cos_val(cy), .sin_val(sy)
  );
  trs_amb_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .FRAC_BITS(FRAC_BITS)) u_cordic_z (
    .clk(clk), .rst(rst), .vld(accept), .angle(angle_z),
    .res_vld(cvz), .cos_val(cz), .sin_val(sz)
  );

  trs_amb_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
    .clk(clk), .rst(rst), .vld(cvx), .cx(cx), .sx(sx), .cy(cy), .sy(sy),
    .cz(cz), .sz(sz), .pose(pd[LAT_C]), .res_vld(rot_vld), .mat(mat),
    .res_pose(rot_pose)
  );

  assign row_sel = row_index + 2'd1;

  always_ff @(posedge clk) begin
    if (rot_vld) begin
      hold <= mat;
      hold_t <= rot_pose.trans;
      row_index <= 2'd0;
      col0 <= mat[0][0];
      col1 <= mat[0][1];
      col2 <= mat[0][2];
      col3 <= rot_pose.trans[0];
    end else if (rows_left != 2'd0) begin
      row_index <= row_sel;
      col0 <= hold[row_sel][0];
      col1 <= hold[row_sel][1];
      col2 <= hold[row_sel][2];
      col3 <= hold_t[row_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      rows_left <= 2'd0;
      last_row <= 1'b0;
    end else if (rot_vld) begin
      strobe <= 1'b1;
      rows_left <= 2'd2;
      last_row <= 1'b0;
    end else if (rows_left != 2'd0) begin
      strobe <= 1'b1;
      rows_left <= rows_left - 2'd1;
      last_row <= (rows_left == 2'd1);
    end else begin
      strobe <= 1'b0;
      last_row <= 1'b0;
    end
  end

  `AMB_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy not raised after a transaction")
  `AMB_ASSERT_SAME(a_cordic_aligned, cvx, cvy && cvz, "CORDIC units out of step")
  `AMB_ASSERT_NEXT(a_row1_follows, strobe && row_index == 2'd0, strobe && row_index == 2'd1,
                   "row 1 did not follow row 0")
  `AMB_ASSERT_NEXT(a_row2_follows, strobe && row_index == 2'd1, strobe && row_index == 2'd2,
                   "row 2 did not follow row 1")
  `AMB_ASSERT_SAME(a_last_is_row2, last_row, strobe && row_index == 2'd2,
                   "last_row marked on a row other than row 2")

endmodule

// ===== tb/trs_amb_checker.sv =====
// Checker for the affine matrix builder: predicts the three matrix rows of each pose and compares.
module trs_amb_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] trans_x,
  input  logic signed [31:0] trans_y,
  input  logic signed [31:0] trans_z,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  input  logic signed [23:0] scale_x,
  input  logic signed [23:0] scale_y,
  input  logic signed [23:0] scale_z,
  input  logic               strobe,
  input  logic [1:0]         row_index,
  input  logic signed [31:0] col0,
  input  logic signed [31:0] col1,
  input  logic signed [31:0] col2,
  input  logic signed [31:0] col3,
  input  logic               last_row,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import trs_amb_pkg::*;

  localparam int STAGES = 16;
  localparam int FB = 16;

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] c0;
    logic [31:0] c1;
    logic [31:0] c2;
    logic [31:0] c3;
    logic        last;
  } row_t;

  row_t expected_rows[$];

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return round_sh(a * b, FB);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic trig(input longint ang, output longint c, output longint s);
    longint x, y, z, nx, dx, dy;
    bit flip;
    flip = 0;
    if (ang > 16384) begin
      ang -= 32768;
      flip = 1;
    end else if (ang < -16384) begin
      ang += 32768;
      flip = 1;
    end
    z = ang * 65536;
    x = round_sh(GAIN_Q30, 30 - FB);
    y = 0;
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        nx = x - dx; y = y + dy; z -= longint'(ATAN_TURN32[i]);
      end else begin
        nx = x + dx; y = y - dy; z += longint'(ATAN_TURN32[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic predict_pose();
    longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
    longint m[3][3];
    longint sc[3];
    longint tr[3];
    row_t r;
    sc = '{longint'(scale_x), longint'(scale_y), longint'(scale_z)};
    tr = '{longint'(trans_x), longint'(trans_y), longint'(trans_z)};
    trig(longint'(angle_x), cx, sx);
    trig(longint'(angle_y), cy, sy);
    trig(longint'(angle_z), cz, sz);
    sxsy = fx_mul(sx, sy);
    cxsy = fx_mul(cx, sy);
    m[0][0] = fx_mul(cy, cz);
    m[0][1] = -fx_mul(cy, sz);
    m[0][2] = sy;
    m[1][0] = fx_mul(sxsy, cz) + fx_mul(cx, sz);
    m[1][1] = fx_mul(cx, cz) - fx_mul(sxsy, sz);
    m[1][2] = -fx_mul(sx, cy);
    m[2][0] = fx_mul(sx, sz) - fx_mul(cxsy, cz);
    m[2][1] = fx_mul(cxsy, sz) + fx_mul(sx, cz);
    m[2][2] = fx_mul(cx, cy);
    for (int k = 0; k < 3; k++) begin
      r.idx = 2'(k);
      r.c0 = 32'(clamp32(round_sh(m[k][0] * sc[0], FB)));
      r.c1 = 32'(clamp32(round_sh(m[k][1] * sc[1], FB)));
      r.c2 = 32'(clamp32(round_sh(m[k][2] * sc[2], FB)));
      r.c3 = 32'(tr[k]);
      r.last = (k == 2);
      expected_rows.push_back(r);
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    row_t e, a;
    if (!rst) begin
      if (start && !busy) predict_pose();
      if (strobe) begin
        a = '{row_index, col0, col1, col2, col3, last_row};
        if (expected_rows.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected row: %p", a);
        end else begin
          e = expected_rows.pop_front();
          if (e !== a) begin
            errors++;
            if (errors <= 10) $display("Row mismatch: expected %p, actual %p", e, a);
          end
        end
      end
    end
    pending = expected_rows.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Testbench top for the affine matrix builder: stimulus, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, strobe, last_row;
  logic signed [31:0] trans_x = 0, trans_y = 0, trans_z = 0;
  logic signed [15:0] angle_x = 0, angle_y = 0, angle_z = 0;
  logic signed [23:0] scale_x = 0, scale_y = 0, scale_z = 0;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;
  int errors, pending, idle_pct, quiet;

  trs_affine_matrix_builder u_top (.*);
  trs_amb_checker u_chk (.*);

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(16'sd16384 + $signed(16'($urandom_range(0, 2))) - 16'sd1);
      3: return 16'(-16'sd16384 + $signed(16'($urandom_range(0, 2))) - 16'sd1);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h010000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Returns at the rising edge that accepts the transaction; start is left high.
  task automatic send_pose(input logic [31:0] tx, ty, tz, input logic [15:0] ax, ay, az,
                           input logic [23:0] sx, sy, sz);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    trans_x <= tx; trans_y <= ty; trans_z <= tz;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    scale_x <= sx; scale_y <= sy; scale_z <= sz;
    start <= 1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random();
    send_pose($urandom, $urandom, $urandom, rand_angle(), rand_angle(), rand_angle(),
              rand_scale(), rand_scale(), rand_scale());
  endtask

  initial begin
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_pose(0, 0, 0, 0, 0, 0, 24'h010000, 24'h010000, 24'h010000);
    send_pose(32'h7fffffff, 32'h80000000, 32'hffffffff, 16'h8000, 16'h8000, 16'h8000,
              24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_pose(32'h80000000, 32'h7fffffff, 1, 16'h7fff, 16'h4000, 16'hc000,
              24'h800000, 24'h800000, 24'h800000);
    send_pose(1, 2, 3, 16'h4000, 16'h4001, 16'hbfff, 24'h7fffff, 24'h800000, 24'hffffff);
    send_pose(32'h55555555, 32'haaaaaaaa, 0, 16'h2000, 16'he000, 16'h5555,
              24'h555555, 24'haaaaaa, 0);
    send_pose(0, 0, 0, 16'hffff, 16'h0001, 16'h1234, 24'h7fffff, 24'h7fffff, 24'h800000);
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 71 : (ph == 3) ? 17 : 0;
      for (int n = 0; n < 101; n++) send_random();
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
